// File: hw/rtl/smc_pkg.sv
// Shared constants and types of the subgraph match counter.
package smc_pkg;

	localparam int MOL_N = 32;
	localparam int PAT_N = 8;
	localparam int MOL_AW = $clog2(MOL_N);
	localparam int PAT_AW = $clog2(PAT_N);
	localparam int CNT_W = $clog2(MOL_N + 1);
	localparam int DEP_W = $clog2(PAT_N + 1);
	localparam int CLR_W = 2 * MOL_AW;
	localparam int LABEL_W = 8;
	localparam int BOND_W = 4;
	localparam int COUNT_W = 40;
	localparam int MSIZE_W = 6;
	localparam int PSIZE_W = 4;
	localparam int IN_W = 32;
	localparam int CFG_AW = 2;
	localparam int CFG_DW = 8;
	localparam logic [LABEL_W-1:0] WILD_RESET = 8'd95;

	typedef enum logic [2:0] {
		FN_CLEAR  = 3'd0,
		FN_MLABEL = 3'd1,
		FN_MBOND  = 3'd2,
		FN_PLABEL = 3'd3,
		FN_PBOND  = 3'd4,
		FN_COUNT  = 3'd5
	} func_t;

	typedef enum logic [CFG_AW-1:0] {
		CFG_MSIZE = 2'd0,
		CFG_PSIZE = 2'd1,
		CFG_WILD  = 2'd2
	} cfg_idx_t;

endpackage

// File: hw/rtl/smc_ram.sv
// Generic RAM with one write port and two registered read ports.
module smc_ram #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 4
) (
	input  logic                       clk,
	input  logic                       we,
	input  logic [$clog2(DEPTH)-1:0]   waddr,
	input  logic [WIDTH-1:0]           wdata,
	input  logic [$clog2(DEPTH)-1:0]   raddr_a,
	input  logic [$clog2(DEPTH)-1:0]   raddr_b,
	output logic [WIDTH-1:0]           rdata_a,
	output logic [WIDTH-1:0]           rdata_b
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end
endmodule

// File: hw/rtl/subgraph_match_counter_top.sv
// Top level of the subgraph match counter: command decode, graph stores and search sequencer.
//
//  channel   dir  handshake              payload
//  s_axis    in   s_tvalid / s_tready    s_tdata: func, atom_a, atom_b, label, bond_order
//  m_axis    out  m_tvalid / m_tready    m_tdata: match_count
//  cfg       in   cfg_valid / cfg_ready  cfg_index, cfg_data
//
// Label commands are taken in the idle state alone; bond commands pass accept, read and two mirrored writes.
// A clear command and reset sweep the bond and label memories while no item is taken.
// A count first groups twin molecule atoms into classes, then runs a depth-first search over classes.
// The result waits in an output register; a new item is taken while it waits.
module subgraph_match_counter_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// func[2:0], atom_a[7:3], atom_b[12:8], label[20:13], bond_order[24:21], zero fill
	input  logic [smc_pkg::IN_W-1:0]      s_tdata,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// match_count[39:0]
	output logic [smc_pkg::COUNT_W-1:0]   m_tdata,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [smc_pkg::CFG_AW-1:0]    cfg_index,
	input  logic [smc_pkg::CFG_DW-1:0]    cfg_data
);
	import smc_pkg::*;

	typedef enum logic [4:0] {
		ST_CLR, ST_IDLE, ST_MB_RD, ST_MB_W1, ST_MB_W2, ST_PB_RD, ST_PB_W1, ST_PB_W2,
		ST_B_U, ST_B_C, ST_B_L, ST_B_W, ST_B_WC, ST_B_IN,
		ST_S_TRY, ST_S_LAB, ST_S_J, ST_S_JC, ST_S_POP, ST_DONE
	} state_t;

	state_t state_q;

	logic [MSIZE_W-1:0] msize_q;
	logic [PSIZE_W-1:0] psize_q;
	logic [LABEL_W-1:0] wild_q;

	logic [CLR_W-1:0]   clr_q;
	logic [4:0]         a_q, b_q;
	logic [BOND_W-1:0]  q_q, bsum_q;

	logic [LABEL_W-1:0] plab_q [PAT_N];

	logic [MOL_AW-1:0]  rep_q   [MOL_N];
	logic [CNT_W-1:0]   size_q  [MOL_N];
	logic [CNT_W-1:0]   used_q  [MOL_N];
	logic [BOND_W-1:0]  inner_q [MOL_N];
	logic [CNT_W-1:0]   ncls_q, u_q, c_q, w_q;

	logic [CNT_W-1:0]   pcls_q [PAT_N];
	logic [CNT_W-1:0]   cst_q  [PAT_N+1];
	logic [COUNT_W-1:0] wt_q   [PAT_N+1];
	logic [DEP_W-1:0]   d_q, j_q;
	logic [COUNT_W-1:0] tot_q;

	logic               out_valid_q;
	logic [COUNT_W-1:0] out_q;

	logic [CLR_W-1:0]        mb_wa, mb_ra, mb_rb;
	logic                    mb_we;
	logic [BOND_W-1:0]       mb_wd, mb_rd_a, mb_rd_b;
	logic [2*PAT_AW-1:0]     pb_wa, pb_ra;
	logic                    pb_we;
	logic [BOND_W-1:0]       pb_wd, pb_rd_a;
	logic [MOL_AW-1:0]       ml_wa, ml_ra, ml_rb;
	logic                    ml_we;
	logic [LABEL_W-1:0]      ml_wd, ml_rd_a, ml_rd_b;

	logic               s_acc;
	func_t              in_func;
	logic [4:0]         in_a, in_b;
	logic [LABEL_W-1:0] in_label;
	logic [BOND_W-1:0]  in_bond;
	logic [CNT_W-1:0]   m_lim;
	logic [DEP_W-1:0]   p_lim;
	logic [MOL_AW-1:0]  c5, cs5, cj5;
	logic [CNT_W-1:0]   cst_d, cj;
	logic [BOND_W:0]    mb_sum, pb_sum;
	logic [BOND_W-1:0]  mb_sat, pb_sat, need;
	logic [COUNT_W-1:0] wt_next;
	logic [DEP_W-1:0]   d_dn;

	assign s_tready  = (state_q == ST_IDLE);
	assign s_acc     = s_tvalid && s_tready;
	assign in_func   = func_t'(s_tdata[2:0]);
	assign in_a      = s_tdata[7:3];
	assign in_b      = s_tdata[12:8];
	assign in_label  = s_tdata[20:13];
	assign in_bond   = s_tdata[24:21];
	assign cfg_ready = 1'b1;
	assign m_tvalid  = out_valid_q;
	assign m_tdata   = out_q;

	assign m_lim = (int'(msize_q) > MOL_N) ? CNT_W'(MOL_N) : CNT_W'(msize_q);
	assign p_lim = (int'(psize_q) > PAT_N) ? DEP_W'(PAT_N) : DEP_W'(psize_q);

	assign c5    = c_q[MOL_AW-1:0];
	assign cst_d = cst_q[d_q];
	assign cs5   = cst_d[MOL_AW-1:0];
	assign cj    = pcls_q[j_q[PAT_AW-1:0]];
	assign cj5   = cj[MOL_AW-1:0];
	assign d_dn  = d_q - DEP_W'(1);

	assign mb_sum = {1'b0, mb_rd_a} + {1'b0, q_q};
	assign mb_sat = mb_sum[BOND_W] ? '1 : mb_sum[BOND_W-1:0];
	assign pb_sum = {1'b0, pb_rd_a} + {1'b0, q_q};
	assign pb_sat = pb_sum[BOND_W] ? '1 : pb_sum[BOND_W-1:0];
	assign need   = (cj == cst_d) ? inner_q[cs5] : mb_rd_a;
	assign wt_next = COUNT_W'(wt_q[d_q] * COUNT_W'(size_q[cs5] - used_q[cs5]));

	always_comb begin
		mb_we = 1'b0;
		mb_wa = {a_q, b_q};
		mb_wd = mb_sat;
		mb_ra = {a_q, b_q};
		mb_rb = {a_q, b_q};
		pb_we = 1'b0;
		pb_wa = {a_q[PAT_AW-1:0], b_q[PAT_AW-1:0]};
		pb_wd = pb_sat;
		pb_ra = {a_q[PAT_AW-1:0], b_q[PAT_AW-1:0]};
		ml_we = 1'b0;
		ml_wa = in_a[MOL_AW-1:0];
		ml_wd = in_label;
		ml_ra = rep_q[c5];
		ml_rb = u_q[MOL_AW-1:0];
		unique case (state_q)
			ST_CLR: begin
				mb_we = 1'b1;
				mb_wa = clr_q;
				mb_wd = '0;
				pb_we = (int'(clr_q) < PAT_N * PAT_N);
				pb_wa = clr_q[2*PAT_AW-1:0];
				pb_wd = '0;
				ml_we = (int'(clr_q) < MOL_N);
				ml_wa = clr_q[MOL_AW-1:0];
				ml_wd = '0;
			end
			ST_IDLE: begin
				ml_we = s_acc && (in_func == FN_MLABEL) && (int'(in_a) < MOL_N);
			end
			ST_MB_W1: begin
				mb_we = 1'b1;
			end
			ST_MB_W2: begin
				mb_we = 1'b1;
				mb_wa = {b_q, a_q};
				mb_wd = bsum_q;
			end
			ST_PB_W1: begin
				pb_we = 1'b1;
			end
			ST_PB_W2: begin
				pb_we = 1'b1;
				pb_wa = {b_q[PAT_AW-1:0], a_q[PAT_AW-1:0]};
				pb_wd = bsum_q;
			end
			ST_B_W: begin
				if (w_q == m_lim) begin
					mb_ra = {rep_q[c5], u_q[MOL_AW-1:0]};
				end else begin
					mb_ra = {rep_q[c5], w_q[MOL_AW-1:0]};
				end
				mb_rb = {u_q[MOL_AW-1:0], w_q[MOL_AW-1:0]};
			end
			ST_S_TRY: begin
				ml_ra = rep_q[cs5];
			end
			ST_S_J: begin
				mb_ra = {rep_q[cs5], rep_q[cj5]};
				pb_ra = {j_q[PAT_AW-1:0], d_q[PAT_AW-1:0]};
			end
			default: begin
			end
		endcase
	end

	smc_ram #(.DEPTH(MOL_N * MOL_N), .WIDTH(BOND_W)) u_mol_bonds (
		.clk(clk), .we(mb_we), .waddr(mb_wa), .wdata(mb_wd),
		.raddr_a(mb_ra), .raddr_b(mb_rb), .rdata_a(mb_rd_a), .rdata_b(mb_rd_b)
	);

	smc_ram #(.DEPTH(PAT_N * PAT_N), .WIDTH(BOND_W)) u_pat_bonds (
		.clk(clk), .we(pb_we), .waddr(pb_wa), .wdata(pb_wd),
		.raddr_a(pb_ra), .raddr_b(pb_ra), .rdata_a(pb_rd_a), .rdata_b()
	);

	smc_ram #(.DEPTH(MOL_N), .WIDTH(LABEL_W)) u_mol_labels (
		.clk(clk), .we(ml_we), .waddr(ml_wa), .wdata(ml_wd),
		.raddr_a(ml_ra), .raddr_b(ml_rb), .rdata_a(ml_rd_a), .rdata_b(ml_rd_b)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLR;
			clr_q       <= '0;
			msize_q     <= MSIZE_W'(1);
			psize_q     <= PSIZE_W'(1);
			wild_q      <= WILD_RESET;
			out_valid_q <= 1'b0;
			for (int i = 0; i < PAT_N; i++) begin
				plab_q[i] <= '0;
			end
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					CFG_MSIZE: msize_q <= cfg_data[MSIZE_W-1:0];
					CFG_PSIZE: psize_q <= cfg_data[PSIZE_W-1:0];
					CFG_WILD:  wild_q  <= cfg_data[LABEL_W-1:0];
					default: begin
					end
				endcase
			end
			if (state_q == ST_DONE && (!out_valid_q || m_tready)) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && m_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLR: begin
					clr_q <= clr_q + CLR_W'(1);
					if (clr_q == '1) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (s_acc) begin
						a_q <= in_a;
						b_q <= in_b;
						q_q <= in_bond;
						unique case (in_func)
							FN_CLEAR: begin
								clr_q   <= '0;
								state_q <= ST_CLR;
								for (int i = 0; i < PAT_N; i++) begin
									plab_q[i] <= '0;
								end
							end
							FN_MLABEL: begin
							end
							FN_MBOND: begin
								if (int'(in_a) < MOL_N && int'(in_b) < MOL_N && in_a != in_b) begin
									state_q <= ST_MB_RD;
								end
							end
							FN_PLABEL: begin
								if (int'(in_a) < PAT_N) begin
									plab_q[in_a[PAT_AW-1:0]] <= in_label;
								end
							end
							FN_PBOND: begin
								if (int'(in_a) < PAT_N && int'(in_b) < PAT_N && in_a != in_b) begin
									state_q <= ST_PB_RD;
								end
							end
							FN_COUNT: begin
								u_q     <= '0;
								ncls_q  <= '0;
								state_q <= ST_B_U;
							end
							default: begin
							end
						endcase
					end
				end
				ST_MB_RD: state_q <= ST_MB_W1;
				ST_MB_W1: begin
					bsum_q  <= mb_sat;
					state_q <= ST_MB_W2;
				end
				ST_MB_W2: state_q <= ST_IDLE;
				ST_PB_RD: state_q <= ST_PB_W1;
				ST_PB_W1: begin
					bsum_q  <= pb_sat;
					state_q <= ST_PB_W2;
				end
				ST_PB_W2: state_q <= ST_IDLE;
				ST_B_U: begin
					c_q <= '0;
					if (u_q == m_lim) begin
						d_q     <= '0;
						wt_q[0] <= COUNT_W'(1);
						cst_q[0] <= '0;
						tot_q   <= '0;
						state_q <= ST_S_TRY;
					end else begin
						state_q <= ST_B_C;
					end
				end
				ST_B_C: begin
					if (c_q == ncls_q) begin
						rep_q[c5]   <= u_q[MOL_AW-1:0];
						size_q[c5]  <= CNT_W'(1);
						inner_q[c5] <= '0;
						used_q[c5]  <= '0;
						ncls_q      <= ncls_q + CNT_W'(1);
						u_q         <= u_q + CNT_W'(1);
						state_q     <= ST_B_U;
					end else begin
						state_q <= ST_B_L;
					end
				end
				ST_B_L: begin
					if (ml_rd_a != ml_rd_b) begin
						c_q     <= c_q + CNT_W'(1);
						state_q <= ST_B_C;
					end else begin
						w_q     <= '0;
						state_q <= ST_B_W;
					end
				end
				ST_B_W: begin
					if (w_q == m_lim) begin
						if (size_q[c5] == CNT_W'(1)) begin
							state_q <= ST_B_IN;
						end else begin
							size_q[c5] <= size_q[c5] + CNT_W'(1);
							u_q        <= u_q + CNT_W'(1);
							state_q    <= ST_B_U;
						end
					end else if (w_q == {1'b0, rep_q[c5]} || w_q == u_q) begin
						w_q <= w_q + CNT_W'(1);
					end else begin
						state_q <= ST_B_WC;
					end
				end
				ST_B_WC: begin
					if (mb_rd_a != mb_rd_b) begin
						c_q     <= c_q + CNT_W'(1);
						state_q <= ST_B_C;
					end else begin
						w_q     <= w_q + CNT_W'(1);
						state_q <= ST_B_W;
					end
				end
				ST_B_IN: begin
					inner_q[c5] <= mb_rd_a;
					size_q[c5]  <= size_q[c5] + CNT_W'(1);
					u_q         <= u_q + CNT_W'(1);
					state_q     <= ST_B_U;
				end
				ST_S_TRY: begin
					if (d_q == p_lim) begin
						tot_q   <= tot_q + wt_q[d_q];
						state_q <= (d_q == '0) ? ST_DONE : ST_S_POP;
					end else if (cst_d == ncls_q) begin
						state_q <= (d_q == '0) ? ST_DONE : ST_S_POP;
					end else if (used_q[cs5] >= size_q[cs5]) begin
						cst_q[d_q] <= cst_d + CNT_W'(1);
					end else begin
						state_q <= ST_S_LAB;
					end
				end
				ST_S_LAB: begin
					if (plab_q[d_q[PAT_AW-1:0]] != wild_q &&
					    plab_q[d_q[PAT_AW-1:0]] != ml_rd_a) begin
						cst_q[d_q] <= cst_d + CNT_W'(1);
						state_q    <= ST_S_TRY;
					end else begin
						j_q     <= '0;
						state_q <= ST_S_J;
					end
				end
				ST_S_J: begin
					if (j_q == d_q) begin
						pcls_q[d_q[PAT_AW-1:0]] <= cst_d;
						used_q[cs5]             <= used_q[cs5] + CNT_W'(1);
						wt_q[d_q + DEP_W'(1)]   <= wt_next;
						cst_q[d_q + DEP_W'(1)]  <= '0;
						d_q                     <= d_q + DEP_W'(1);
						state_q                 <= ST_S_TRY;
					end else begin
						state_q <= ST_S_JC;
					end
				end
				ST_S_JC: begin
					if (need != pb_rd_a) begin
						cst_q[d_q] <= cst_d + CNT_W'(1);
						state_q    <= ST_S_TRY;
					end else begin
						j_q     <= j_q + DEP_W'(1);
						state_q <= ST_S_J;
					end
				end
				ST_S_POP: begin
					used_q[cst_q[d_dn][MOL_AW-1:0]] <= used_q[cst_q[d_dn][MOL_AW-1:0]] - CNT_W'(1);
					cst_q[d_dn] <= cst_q[d_dn] + CNT_W'(1);
					d_q         <= d_dn;
					state_q     <= ST_S_TRY;
				end
				ST_DONE: begin
					if (!out_valid_q || m_tready) begin
						out_q   <= tot_q;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

// File: tb/subgraph_match_counter_top_tb.sv
// Self-checking testbench of subgraph_match_counter_top with a scoreboard that counts matches.
module subgraph_match_counter_top_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import smc_pkg::*;

	localparam longint unsigned COUNT_CAP = (64'd1 << COUNT_W) - 1;
	localparam int CYCLE_LIMIT = 10000000;
	localparam int SETTLE_CYCLES = 2000;

	class match_scoreboard;
		logic [LABEL_W-1:0] mol_label[MOL_N];
		logic [BOND_W-1:0] mol_bond[MOL_N][MOL_N];
		logic [LABEL_W-1:0] pat_label[PAT_N];
		logic [BOND_W-1:0] pat_bond[PAT_N][PAT_N];
		logic [MSIZE_W-1:0] mol_size;
		logic [PSIZE_W-1:0] pat_size;
		logic [LABEL_W-1:0] wild;
		logic [COUNT_W-1:0] counts_due[$];
		int errors;
		int counts_seen;
		int ncls;
		int cls_rep[MOL_N];
		int cls_size[MOL_N];
		int cls_used[MOL_N];
		logic [BOND_W-1:0] cls_inner[MOL_N];
		int pat_cls[PAT_N];
		int depth_n;

		function new();
			clear_graphs();
			mol_size = 1;
			pat_size = 1;
			wild = WILD_RESET;
			errors = 0;
			counts_seen = 0;
		endfunction

		function void clear_graphs();
			foreach (mol_label[i]) mol_label[i] = '0;
			foreach (mol_bond[i, j]) mol_bond[i][j] = '0;
			foreach (pat_label[i]) pat_label[i] = '0;
			foreach (pat_bond[i, j]) pat_bond[i][j] = '0;
		endfunction

		function void write_reg(cfg_idx_t idx, logic [CFG_DW-1:0] value);
			case (idx)
				CFG_MSIZE: mol_size = value[MSIZE_W-1:0];
				CFG_PSIZE: pat_size = value[PSIZE_W-1:0];
				CFG_WILD: wild = value;
				default: ;
			endcase
		endfunction

		function logic [BOND_W-1:0] bond_sum(logic [BOND_W-1:0] a, logic [BOND_W-1:0] b);
			int s;
			s = a + b;
			return (s > 15) ? 4'd15 : s[BOND_W-1:0];
		endfunction

		function bit twins(int u, int v, int m);
			if (mol_label[u] != mol_label[v]) return 0;
			for (int w = 0; w < m; w++)
				if (w != u && w != v && mol_bond[u][w] != mol_bond[v][w]) return 0;
			return 1;
		endfunction

		function longint unsigned sat_mul(longint unsigned a, longint unsigned b);
			if (a == 0 || b == 0) return 0;
			if (a > COUNT_CAP / b) return COUNT_CAP;
			return a * b;
		endfunction

		function longint unsigned walk(int d, longint unsigned weight);
			longint unsigned total;
			logic [BOND_W-1:0] need;
			int taken;
			bit ok;
			total = 0;
			if (d >= depth_n) return weight;
			for (int c = 0; c < ncls && total < COUNT_CAP; c++) begin
				taken = cls_used[c];
				if (taken >= cls_size[c]) continue;
				if (pat_label[d] != wild && pat_label[d] != mol_label[cls_rep[c]]) continue;
				ok = 1;
				for (int j = 0; j < d; j++) begin
					need = (pat_cls[j] == c) ? cls_inner[c] : mol_bond[cls_rep[c]][cls_rep[pat_cls[j]]];
					if (need != pat_bond[j][d]) ok = 0;
				end
				if (!ok) continue;
				pat_cls[d] = c;
				cls_used[c] = taken + 1;
				total += walk(d + 1, sat_mul(weight, cls_size[c] - taken));
				if (total > COUNT_CAP) total = COUNT_CAP;
				cls_used[c] = taken;
			end
			return total;
		endfunction

		function longint unsigned count_maps();
			int m;
			int c;
			m = (mol_size > MOL_N) ? MOL_N : mol_size;
			depth_n = (pat_size > PAT_N) ? PAT_N : pat_size;
			ncls = 0;
			for (int u = 0; u < m; u++) begin
				for (c = 0; c < ncls; c++)
					if (twins(cls_rep[c], u, m)) break;
				if (c < ncls) begin
					if (cls_size[c] == 1) cls_inner[c] = mol_bond[cls_rep[c]][u];
					cls_size[c]++;
				end else begin
					cls_rep[c] = u;
					cls_size[c] = 1;
					cls_inner[c] = '0;
					cls_used[c] = 0;
					ncls++;
				end
			end
			return walk(0, 1);
		endfunction

		function void note_command(logic [2:0] fn, logic [4:0] a, logic [4:0] b,
				logic [LABEL_W-1:0] lab, logic [BOND_W-1:0] q);
			longint unsigned n;
			case (fn)
				FN_CLEAR: clear_graphs();
				FN_MLABEL: mol_label[a] = lab;
				FN_MBOND: if (a != b) begin
					mol_bond[a][b] = bond_sum(mol_bond[a][b], q);
					mol_bond[b][a] = mol_bond[a][b];
				end
				FN_PLABEL: if (a < PAT_N) pat_label[a] = lab;
				FN_PBOND: if (a < PAT_N && b < PAT_N && a != b) begin
					pat_bond[a][b] = bond_sum(pat_bond[a][b], q);
					pat_bond[b][a] = pat_bond[a][b];
				end
				FN_COUNT: begin
					n = count_maps();
					counts_due = {counts_due, n[COUNT_W-1:0]};
				end
				default: ;
			endcase
		endfunction

		function void check_count(logic [COUNT_W-1:0] got);
			if (counts_due.size() == 0) begin
				$display("%0t: unexpected match_count transfer, expected none, actual %0d",
					$time, got);
				errors++;
				return;
			end
			counts_seen++;
			if (got !== counts_due[0]) begin
				$display("%0t: match_count mismatch, expected %0d, actual %0d",
					$time, counts_due[0], got);
				errors++;
			end
			void'(counts_due.pop_front());
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [IN_W-1:0] s_tdata;
	logic m_tvalid;
	logic m_tready;
	logic [COUNT_W-1:0] m_tdata;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_AW-1:0] cfg_index;
	logic [CFG_DW-1:0] cfg_data;

	match_scoreboard board;
	int cycles;
	int send_idle;
	int recv_idle;
	int items_sent;
	int span;

	subgraph_match_counter_top dut (.*);

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles.", cycles);
			$display("subgraph_match_counter_top verification failed");
			$finish;
		end
	end

	initial begin
		m_tready = 0;
		forever begin
			@(posedge clk);
			if (arst_n && m_tvalid && m_tready) board.check_count(m_tdata);
			@(negedge clk);
			m_tready <= ($urandom_range(99) >= recv_idle);
		end
	end

	task automatic write_reg(cfg_idx_t idx, int value);
		@(negedge clk);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= value[CFG_DW-1:0];
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		board.write_reg(idx, value[CFG_DW-1:0]);
		@(negedge clk);
		cfg_valid <= 0;
	endtask

	task automatic send_command(logic [2:0] fn, int a, int b, int lab, int q);
		int gap;
		gap = ($urandom_range(99) < send_idle) ? $urandom_range(1, 4) : 0;
		@(negedge clk);
		if (gap > 0) begin
			s_tvalid <= 0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1;
		s_tdata <= {7'd0, q[3:0], lab[7:0], b[4:0], a[4:0], fn};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		board.note_command(fn, a[4:0], b[4:0], lab[7:0], q[3:0]);
		items_sent++;
		if (items_sent == 150) begin
			send_idle = 49;
			recv_idle = 9;
		end else if (items_sent == 300) begin
			send_idle = 0;
			recv_idle = 0;
		end
	endtask

	task automatic settle();
		@(negedge clk);
		s_tvalid <= 0;
		while (board.counts_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic int pick_label();
		int r;
		r = $urandom_range(9);
		if (r == 0) return $urandom_range(255);
		if (r == 1) return board.wild;
		if (r < 5) return 67;
		if (r < 7) return 79;
		return 78;
	endfunction

	task automatic random_block(int msize, int psize, int wildc, int width, int count);
		int r;
		int pspan;
		write_reg(CFG_MSIZE, msize);
		write_reg(CFG_PSIZE, psize);
		write_reg(CFG_WILD, wildc);
		span = width;
		pspan = (width < PAT_N) ? width : PAT_N;
		send_command(FN_CLEAR, 0, 0, 0, 0);
		for (int k = 0; k < count; k++) begin
			r = $urandom_range(99);
			if (r < 2)
				send_command(FN_CLEAR, $urandom_range(31), $urandom_range(31), 0, 0);
			else if (r < 4)
				send_command($urandom_range(6, 7), $urandom_range(31), $urandom_range(31),
					$urandom_range(255), $urandom_range(15));
			else if (r < 24)
				send_command(FN_MLABEL, ($urandom_range(9) == 0) ? $urandom_range(31) :
					$urandom_range(span - 1), 0, pick_label(), 0);
			else if (r < 48)
				send_command(FN_MBOND,
					($urandom_range(9) == 0) ? $urandom_range(31) : $urandom_range(span - 1),
					$urandom_range(span - 1), 0,
					($urandom_range(9) == 0) ? $urandom_range(15) : $urandom_range(1, 2));
			else if (r < 60)
				send_command(FN_PLABEL, ($urandom_range(9) == 0) ? $urandom_range(31) :
					$urandom_range(pspan - 1), 0, pick_label(), 0);
			else if (r < 78)
				send_command(FN_PBOND,
					($urandom_range(9) == 0) ? $urandom_range(31) : $urandom_range(pspan - 1),
					$urandom_range(pspan - 1), 0,
					($urandom_range(9) == 0) ? $urandom_range(15) : $urandom_range(1, 2));
			else
				send_command(FN_COUNT, $urandom_range(31), $urandom_range(31),
					$urandom_range(255), $urandom_range(15));
		end
		settle();
	endtask

	initial begin
		board = new();
		cycles = 0;
		items_sent = 0;
		send_idle = 9;
		recv_idle = 49;
		arst_n = 0;
		s_tvalid = 0;
		s_tdata = '0;
		cfg_valid = 0;
		cfg_index = CFG_MSIZE;
		cfg_data = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// Reset values first, then extremes of every field and the ignored cases.
		send_command(FN_COUNT, 0, 0, 0, 0);
		send_command(6, 31, 31, 255, 15);
		send_command(7, 0, 0, 0, 0);
		send_command(FN_MLABEL, 31, 0, 255, 0);
		send_command(FN_MLABEL, 0, 0, 67, 0);
		send_command(FN_MLABEL, 1, 0, 67, 0);
		send_command(FN_MBOND, 2, 2, 0, 15);
		send_command(FN_MBOND, 0, 31, 0, 15);
		send_command(FN_MBOND, 31, 0, 0, 15);
		send_command(FN_MBOND, 0, 1, 0, 1);
		send_command(FN_PLABEL, 31, 0, 67, 0);
		send_command(FN_PLABEL, 7, 0, 255, 0);
		send_command(FN_PLABEL, 0, 0, 67, 0);
		send_command(FN_PBOND, 0, 9, 0, 15);
		send_command(FN_PBOND, 1, 1, 0, 15);
		send_command(FN_PBOND, 0, 1, 0, 1);
		send_command(FN_COUNT, 31, 31, 255, 15);
		settle();
		write_reg(CFG_MSIZE, 0);
		write_reg(CFG_PSIZE, 0);
		send_command(FN_COUNT, 0, 0, 0, 0);
		settle();
		write_reg(CFG_PSIZE, 2);
		send_command(FN_COUNT, 0, 0, 0, 0);
		settle();
		write_reg(CFG_MSIZE, 63);
		write_reg(CFG_PSIZE, 15);
		write_reg(CFG_WILD, 255);
		send_command(FN_COUNT, 0, 0, 0, 0);
		send_command(FN_CLEAR, 0, 0, 0, 0);
		send_command(FN_COUNT, 0, 0, 0, 0);
		settle();

		random_block(6, 3, 95, 6, 90);
		random_block(8, 4, 67, 8, 90);
		random_block(0, 0, 0, 8, 20);
		random_block(4, 8, 95, 6, 50);
		random_block(63, 15, 255, 10, 40);
		random_block(32, 2, 0, 12, 20);
		random_block(7, 5, 42, 7, 140);

		$display("Sent %0d commands over several size and wildcard settings; %0d counts checked.",
			items_sent, board.counts_seen);
		$display("Sender and receiver stalls were varied, then both were removed.");
		if (board.errors == 0)
			$display("subgraph_match_counter_top verification clean");
		else
			$display("subgraph_match_counter_top verification failed");
		$finish;
	end
endmodule
